/* sv/tequ_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tequ_pkg
// Types and constants shared by the timed event ring queue and its checker.
// ----------------------------------------------------------------------------
package tequ_pkg;

   localparam int CODE_W = 8;
   localparam int WORD_W = 32;

   // request operation codes
   localparam logic OP_ADD = 1'b0;
   localparam logic OP_RUN = 1'b1;

   localparam logic [CODE_W-1:0] CODE_NONE = '0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FETCH,
      ST_EMIT
   } state_type;

   // one slot of the ring
   typedef struct packed {
      logic [CODE_W-1:0] code;
      logic [WORD_W-1:0] payload;
      logic [WORD_W-1:0] due;
   } slot_type;

   // one response
   typedef struct packed {
      logic              accepted;
      logic [CODE_W-1:0] code;
      logic [WORD_W-1:0] data;
   } res_type;

endpackage : tequ_pkg
`default_nettype wire

/* sv/timed_event_ring_queue.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// timed_event_ring_queue
// Ring queue of timed events kept in a synchronous slot memory.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel: op 0 adds an event (code, data, due = uptime + delay) at the
//   tail slot; op 1 pops the head event and either returns it (due) or puts it
//   back at the tail (not yet due). Every request gives exactly one response.
//   rsp_* channel: accepted flag for an add, code and data of a due event.
// Sequencing:
//   an add or a run on an empty head slot goes straight to ST_EMIT; a run on an
//   occupied slot first passes ST_FETCH (registered slot memory read, then
//   compare and write back). A new request is taken as soon as the previous
//   one has moved into the response register; requests are handled one at a time.
// Stalls:
//   the response register holds its value while rsp_ready is low; one more
//   request may be taken and finished behind it, then req_ready drops.
// Reset:
//   synchronous; head, tail and the per-slot occupancy flags clear, so the
//   queue is empty and usable right after reset.
// ----------------------------------------------------------------------------
module timed_event_ring_queue #(
   parameter int QUEUE_DEPTH = 8
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_ready,
   input  wire                       req_op,
   input  wire [tequ_pkg::CODE_W-1:0] req_event_code,
   input  wire [tequ_pkg::WORD_W-1:0] req_event_data,
   input  wire [tequ_pkg::WORD_W-1:0] req_delay,
   input  wire [tequ_pkg::WORD_W-1:0] req_uptime,
   output logic                      rsp_valid,
   input  wire                       rsp_ready,
   output logic                      rsp_accepted,
   output logic [tequ_pkg::CODE_W-1:0] rsp_out_code,
   output logic [tequ_pkg::WORD_W-1:0] rsp_out_data
);
   import tequ_pkg::*;

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i);
      logic [IDX_W-1:0] r;
      if (i == IDX_W'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = i + 1'b1;
      end
      return r;
   endfunction

   state_type            state_ff, state_in;
   logic [IDX_W-1:0]     head_ff, head_in;
   logic [IDX_W-1:0]     tail_ff, tail_in;
   logic [QUEUE_DEPTH-1:0] occ_ff, occ_in;
   logic [WORD_W-1:0]    now_ff, now_in;
   res_type              res_ff, res_in;
   res_type              rsp_ff, rsp_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   slot_type             rd_ff;

   logic                 mem_we;
   slot_type             mem_wdata;
   logic [WORD_W-1:0]    due_sum;

   // slot memory, read address is always the head
   slot_type             slot_mem [QUEUE_DEPTH];

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[tail_ff] <= mem_wdata;
      end
      rd_ff <= slot_mem[head_ff];
   end

   assign due_sum = req_uptime + req_delay;

   // requests are spaced so a write never overlaps the head read that ST_FETCH uses
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      occ_in       = occ_ff;
      now_in       = now_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      mem_we       = 1'b0;
      mem_wdata    = rd_ff;
      req_ready    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               res_in = '0;
               now_in = req_uptime;
               if (req_op == OP_ADD) begin
                  state_in = ST_EMIT;
                  if (req_event_code != CODE_NONE && !occ_ff[tail_ff]) begin
                     mem_we          = 1'b1;
                     mem_wdata.code    = req_event_code;
                     mem_wdata.payload = req_event_data;
                     mem_wdata.due     = due_sum;
                     occ_in[tail_ff] = 1'b1;
                     tail_in         = next_idx(tail_ff);
                     res_in.accepted = 1'b1;
                  end
               end else if (occ_ff[head_ff]) begin
                  state_in = ST_FETCH;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_FETCH: begin
            occ_in[head_ff] = 1'b0;
            head_in         = next_idx(head_ff);
            state_in        = ST_EMIT;
            if (now_ff < rd_ff.due) begin
               // not due yet: back in at the tail, the head slot is free now
               if (tail_ff == head_ff || !occ_ff[tail_ff]) begin
                  mem_we          = 1'b1;
                  occ_in[tail_ff] = 1'b1;
                  tail_in         = next_idx(tail_ff);
               end
            end else begin
               res_in.code = rd_ff.code;
               res_in.data = rd_ff.payload;
            end
         end
         ST_EMIT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         occ_ff       <= occ_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      res_ff <= res_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = rsp_ff.accepted;
   assign rsp_out_code = rsp_ff.code;
   assign rsp_out_data = rsp_ff.data;

endmodule : timed_event_ring_queue
`default_nettype wire

/* sv/tequ_checker.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tequ_checker
// Port-level checks for the timed event ring queue, bound to the top level.
// ----------------------------------------------------------------------------
module tequ_checker (
   input wire                         clock,
   input wire                         reset,
   input wire                         rsp_valid,
   input wire                         rsp_ready,
   input wire                         rsp_accepted,
   input wire [tequ_pkg::CODE_W-1:0]  rsp_out_code,
   input wire [tequ_pkg::WORD_W-1:0]  rsp_out_data
);
   import tequ_pkg::*;

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_accepted)
         && $stable(rsp_out_code) && $stable(rsp_out_data))
      else $error("response changed while stalled");

   // an accepted add never carries an event
   a_add_no_event: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_accepted |-> rsp_out_code == CODE_NONE && rsp_out_data == '0)
      else $error("accepted add carries event data");

   // no event means no payload
   a_empty_no_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_out_code == CODE_NONE |-> rsp_out_data == '0)
      else $error("payload without event code");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

endmodule : tequ_checker

bind timed_event_ring_queue tequ_checker u_tequ_checker (.*);
`default_nettype wire
